// ----- sv/tlvps_pkg.sv -----
`timescale 1ns / 1ps

package tlvps_pkg;

    // Width of the big-endian length field of a record, in bytes.
    localparam int unsigned LEN_BYTES = 3;
    localparam int unsigned LEN_IDX_W = 2;
    localparam int unsigned LEN_CNT_W = LEN_IDX_W + 1;
    localparam int unsigned ACC_W     = 24;

    localparam logic [7:0] TYPE_PAD_SINGLE = 8'd0;
    localparam logic [7:0] TYPE_PADN       = 8'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tlvps_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       stream_end;
        logic       truncated;
    } tlvps_result_t;

endpackage

// ----- sv/tlv_padding_stripper.sv -----
`timescale 1ns / 1ps

// Padding stripper for a stored type-length-value file, one byte per beat.
// Input channel: in_valid, in_stall, in_byte, in_last (in_last marks the final byte).
// Output channel: out_valid, out_stall, out_byte, keep, stream_end, truncated.
// Every input beat gives exactly one output beat with the byte echoed and a keep
// flag; Pad1 and PadN records are marked with keep low, everything else high.
// The register header_bytes is written with cfg_write_en and takes effect at once;
// write it only while no beats are in flight.
// An accepted input beat reaches its output beat through an input register and a
// result register. One beat is taken every cycle unless an output stall backs up both.
// Reset clears both stages, returns the parser to the header phase and sets
// header_bytes to 4. A stall on the output holds the result register and, once the
// input register is also full, raises in_stall in the same cycle.
// The final byte returns the parser to the header phase for the next file.

module tlv_padding_stripper
    import tlvps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] header_bytes,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       keep,
    output logic       stream_end,
    output logic       truncated
);

    logic          advance;
    logic          item_valid;
    tlvps_item_t   item;
    tlvps_result_t result;

    tlvps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tlvps_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .header_bytes (header_bytes),
        .item_fire    (item_valid && advance),
        .item         (item),
        .result       (result)
    );

    tlvps_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .keep       (keep),
        .stream_end (stream_end),
        .truncated  (truncated)
    );

endmodule

// ----- sv/tlvps_in_stage.sv -----
`timescale 1ns / 1ps

module tlvps_in_stage
    import tlvps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        advance,
    output logic        item_valid,
    output tlvps_item_t item
);

    logic        valid_reg;
    logic        valid_next;
    tlvps_item_t item_reg;
    logic        load;

    assign load       = !valid_reg || advance;
    assign valid_next = load ? in_valid : valid_reg;
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg.data <= in_byte;
            item_reg.last <= in_last;
        end
    end

endmodule

// ----- sv/tlvps_parser.sv -----
`timescale 1ns / 1ps

module tlvps_parser
    import tlvps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [7:0]    header_bytes,
    input  logic          item_fire,
    input  tlvps_item_t   item,
    output tlvps_result_t result
);

    logic [7:0]           header_bytes_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [7:0]           header_count_reg;
    logic [7:0]           header_count_next;
    logic [LEN_IDX_W-1:0] length_index_reg;
    logic [LEN_IDX_W-1:0] length_index_next;
    logic [ACC_W-1:0]     length_acc_reg;
    logic [ACC_W-1:0]     length_acc_next;
    logic [ACC_W-1:0]     bytes_remaining_reg;
    logic [ACC_W-1:0]     bytes_remaining_next;
    logic                 dropping_reg;
    logic                 dropping_next;

    phase_t               phase_eff;
    phase_t               phase_upd;
    logic [7:0]           header_count_inc;
    logic [ACC_W-1:0]     length_acc_sum;
    logic [LEN_CNT_W-1:0] length_index_sum;
    logic [ACC_W-1:0]     bytes_remaining_dec;
    logic                 keep;

    // A header already complete (or cut short by a register write) parses as a type byte.
    assign phase_eff = (phase_reg == PH_HEADER && header_count_reg >= header_bytes_reg)
                       ? PH_TYPE : phase_reg;

    assign header_count_inc    = header_count_reg + 8'd1;
    assign length_acc_sum      = {length_acc_reg[ACC_W-9:0], item.data};
    assign length_index_sum    = {1'b0, length_index_reg} + LEN_CNT_W'(1);
    assign bytes_remaining_dec = bytes_remaining_reg - ACC_W'(1);

    always_comb
    begin
        phase_upd            = phase_eff;
        header_count_next    = header_count_reg;
        length_index_next    = length_index_reg;
        length_acc_next      = length_acc_reg;
        bytes_remaining_next = bytes_remaining_reg;
        dropping_next        = dropping_reg;
        case (phase_eff)
            PH_HEADER:
            begin
                header_count_next = header_count_inc;
                if (header_count_inc >= header_bytes_reg)
                begin
                    phase_upd = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (item.data != TYPE_PAD_SINGLE)
                begin
                    dropping_next     = (item.data == TYPE_PADN);
                    length_index_next = '0;
                    length_acc_next   = '0;
                    phase_upd         = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                length_acc_next = length_acc_sum;
                if (length_index_sum >= LEN_CNT_W'(LEN_BYTES))
                begin
                    length_index_next = '0;
                    if (length_acc_sum == '0)
                    begin
                        phase_upd = PH_TYPE;
                    end
                    else
                    begin
                        bytes_remaining_next = length_acc_sum;
                        phase_upd            = PH_BODY;
                    end
                end
                else
                begin
                    length_index_next = length_index_sum[LEN_IDX_W-1:0];
                end
            end
            PH_BODY:
            begin
                bytes_remaining_next = bytes_remaining_dec;
                if (bytes_remaining_dec == '0)
                begin
                    phase_upd = PH_TYPE;
                end
            end
            default:
            begin
                phase_upd = PH_HEADER;
            end
        endcase
        phase_next = phase_upd;
        if (item.last)
        begin
            phase_next           = PH_HEADER;
            header_count_next    = '0;
            length_index_next    = '0;
            length_acc_next      = '0;
            bytes_remaining_next = '0;
            dropping_next        = 1'b0;
        end
    end

    always_comb
    begin
        case (phase_eff)
            PH_HEADER: keep = 1'b1;
            PH_TYPE:   keep = (item.data != TYPE_PAD_SINGLE) && (item.data != TYPE_PADN);
            PH_LENGTH: keep = !dropping_reg;
            PH_BODY:   keep = !dropping_reg;
            default:   keep = 1'b0;
        endcase
        result.data       = item.data;
        result.keep       = keep;
        result.stream_end = item.last;
        result.truncated  = item.last && (phase_upd == PH_LENGTH || phase_upd == PH_BODY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg    <= 8'd4;
            phase_reg           <= PH_HEADER;
            header_count_reg    <= '0;
            length_index_reg    <= '0;
            length_acc_reg      <= '0;
            bytes_remaining_reg <= '0;
            dropping_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                header_bytes_reg <= header_bytes;
            end
            if (item_fire)
            begin
                phase_reg           <= phase_next;
                header_count_reg    <= header_count_next;
                length_index_reg    <= length_index_next;
                length_acc_reg      <= length_acc_next;
                bytes_remaining_reg <= bytes_remaining_next;
                dropping_reg        <= dropping_next;
            end
        end
    end

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.last |=> phase_reg == PH_HEADER && header_count_reg == 8'd0
                                    && dropping_reg == 1'b0)
        else $error("state not cleared after final beat");

    a_length_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, length_index_reg} < LEN_CNT_W'(LEN_BYTES))
        else $error("length index out of range");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> bytes_remaining_reg != '0)
        else $error("body phase with no bytes remaining");

endmodule

// ----- sv/tlvps_out_stage.sv -----
`timescale 1ns / 1ps

module tlvps_out_stage
    import tlvps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  tlvps_result_t result,
    output logic          advance,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          keep,
    output logic          stream_end,
    output logic          truncated
);

    logic          valid_reg;
    logic          valid_next;
    tlvps_result_t result_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? item_valid : valid_reg;

    assign out_valid  = valid_reg;
    assign out_byte   = result_reg.data;
    assign keep       = result_reg.keep;
    assign stream_end = result_reg.stream_end;
    assign truncated  = result_reg.truncated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

    a_truncated_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_reg.truncated |-> result_reg.stream_end)
        else $error("truncated flag on a beat that is not the final one");

endmodule

// ----- sim/tb_tlv_padding_stripper.sv -----
`timescale 1ns / 1ps

module tb_tlv_padding_stripper;

    import tlvps_pkg::*;

    localparam int unsigned ITEMS   = 1700;
    localparam int unsigned RX_HOLD = 60;

    class strip_scoreboard;
        logic [7:0]       hdr_len;
        phase_t           parse_phase;
        logic [7:0]       hdr_seen;
        int unsigned      len_count;
        logic [ACC_W-1:0] len_acc;
        logic [ACC_W-1:0] body_left;
        logic             pad_record;
        tlvps_result_t    expected_marks[$];
        int unsigned      errors;

        function new();
            hdr_len = 8'd4;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            parse_phase = PH_HEADER;
            hdr_seen    = '0;
            len_count   = 0;
            len_acc     = '0;
            body_left   = '0;
            pad_record  = 1'b0;
        endfunction

        function void set_header_len(logic [7:0] value);
            hdr_len = value;
        endfunction

        function int unsigned pending();
            return expected_marks.size();
        endfunction

        function void note_beat(logic [7:0] data, logic last);
            tlvps_result_t mark;
            mark.data       = data;
            mark.keep       = 1'b0;
            mark.stream_end = last;
            mark.truncated  = 1'b0;
            if (parse_phase == PH_HEADER && hdr_seen >= hdr_len)
            begin
                parse_phase = PH_TYPE;
            end
            case (parse_phase)
                PH_HEADER:
                begin
                    mark.keep = 1'b1;
                    hdr_seen  = hdr_seen + 8'd1;
                    if (hdr_seen >= hdr_len)
                    begin
                        parse_phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (data != TYPE_PAD_SINGLE)
                    begin
                        pad_record  = (data == TYPE_PADN);
                        mark.keep   = !pad_record;
                        len_count   = 0;
                        len_acc     = '0;
                        parse_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    mark.keep = !pad_record;
                    len_acc   = {len_acc[ACC_W-9:0], data};
                    len_count = len_count + 1;
                    if (len_count >= LEN_BYTES)
                    begin
                        len_count = 0;
                        if (len_acc == '0)
                        begin
                            parse_phase = PH_TYPE;
                        end
                        else
                        begin
                            body_left   = len_acc;
                            parse_phase = PH_BODY;
                        end
                    end
                end
                default:
                begin
                    mark.keep = !pad_record;
                    body_left = body_left - 1'b1;
                    if (body_left == '0)
                    begin
                        parse_phase = PH_TYPE;
                    end
                end
            endcase
            if (last)
            begin
                mark.truncated = (parse_phase == PH_LENGTH || parse_phase == PH_BODY);
                restart();
            end
            expected_marks.push_back(mark);
        endfunction

        function void compare_field(string name, logic [7:0] expv, logic [7:0] actv);
            if (expv !== actv)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void check_beat(logic [7:0] data, logic keep_bit, logic end_bit,
                                 logic trunc_bit);
            tlvps_result_t mark;
            if (expected_marks.size() == 0)
            begin
                $display("%0t: output beat with nothing expected, expected none, actual %0h",
                         $time, data);
                errors++;
                return;
            end
            mark = expected_marks.pop_front();
            compare_field("out_byte", mark.data, data);
            compare_field("keep", {7'd0, mark.keep}, {7'd0, keep_bit});
            compare_field("stream_end", {7'd0, mark.stream_end}, {7'd0, end_bit});
            compare_field("truncated", {7'd0, mark.truncated}, {7'd0, trunc_bit});
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_en;
    logic [7:0] header_bytes;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       keep;
    logic       stream_end;
    logic       truncated;

    strip_scoreboard strip_sb;
    logic [7:0]      file_data[$];
    int unsigned     sent_beats;
    logic            tx_idle_on;
    logic            rx_idle_on;
    logic            rx_hold_req;

    tlv_padding_stripper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .header_bytes (header_bytes),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .keep         (keep),
        .stream_end   (stream_end),
        .truncated    (truncated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                strip_sb.check_beat(out_byte, keep, stream_end, truncated);
            end
            if (in_valid && !in_stall)
            begin
                strip_sb.note_beat(in_byte, in_last);
            end
            if (cfg_write_en)
            begin
                strip_sb.set_header_len(header_bytes);
            end
        end
    end

    initial
    begin
        int unsigned hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold = RX_HOLD;
            end
            else
            begin
                hold = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= data;
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_beats++;
    endtask

    task automatic send_range(input int unsigned first, input int unsigned stop);
        for (int unsigned i = first; i < stop; i++)
        begin
            send_beat(file_data[i], i == file_data.size() - 1);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (strip_sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] value);
        cfg_write_en <= 1'b1;
        header_bytes <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic build_file(input int unsigned hdr);
        int unsigned n_rec;
        int unsigned kind;
        int unsigned len;
        file_data.delete();
        for (int unsigned i = 0; i < hdr; i++)
        begin
            file_data.push_back(8'($urandom_range(0, 255)));
        end
        n_rec = $urandom_range(0, 6);
        for (int unsigned r = 0; r < n_rec; r++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                file_data.push_back(TYPE_PAD_SINGLE);
            end
            else
            begin
                if (kind <= 3)
                begin
                    file_data.push_back(TYPE_PADN);
                end
                else
                begin
                    file_data.push_back(8'($urandom_range(2, 255)));
                end
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                if ($urandom_range(0, 15) == 0)
                begin
                    len = $urandom_range(13, 60);
                end
                for (int k = LEN_BYTES - 1; k >= 0; k--)
                begin
                    file_data.push_back(8'(len >> (8 * k)));
                end
                for (int unsigned j = 0; j < len; j++)
                begin
                    file_data.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 16)) file_data.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 1 && file_data.size() > 1)
        begin
            len = $urandom_range(1, file_data.size() - 1);
            while (file_data.size() > len)
            begin
                void'(file_data.pop_back());
            end
        end
        if (file_data.size() == 0)
        begin
            file_data.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned phase_start;
        int unsigned split_at;
        int unsigned mode;
        logic [7:0]  next_hdr;

        strip_sb     = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        header_bytes = 8'd4;
        in_valid     = 1'b0;
        in_byte      = 8'd0;
        in_last      = 1'b0;
        sent_beats   = 0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        rx_hold_req  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // A full file under the reset header length, ending just after a type byte.
        file_data = '{8'h00, 8'hFF, 8'hAA, 8'h55, TYPE_PAD_SINGLE,
                      TYPE_PADN, 8'h00, 8'h00, 8'h02, 8'h12, 8'h34,
                      8'hFF, 8'h00, 8'h00, 8'h00,
                      8'h02, 8'h00, 8'h00, 8'h01, 8'h80, 8'h03};
        send_range(0, file_data.size());
        // The file ends inside its header.
        file_data = '{8'h7E, 8'h81, 8'hC3};
        send_range(0, file_data.size());
        wait_idle();
        write_cfg(8'd0);
        file_data = '{TYPE_PAD_SINGLE};
        send_range(0, file_data.size());

        phase_no = 0;
        while (sent_beats < ITEMS)
        begin
            wait_idle();
            case (phase_no)
                0: next_hdr = 8'd255;
                1: next_hdr = 8'd0;
                2: next_hdr = 8'd1;
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        next_hdr = 8'($urandom_range(0, 255));
                    end
                    else
                    begin
                        next_hdr = 8'($urandom_range(0, 10));
                    end
                end
            endcase
            write_cfg(next_hdr);
            mode = $urandom_range(0, 3);
            tx_idle_on = mode[0];
            rx_idle_on = mode[1];
            if (phase_no == 3)
            begin
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            phase_start = sent_beats;
            while (sent_beats - phase_start < 100)
            begin
                build_file(strip_sb.hdr_len);
                if ($urandom_range(0, 5) == 0 && file_data.size() > 1)
                begin
                    // The header length changes while the parser is part way through a file.
                    split_at = $urandom_range(1, file_data.size() - 1);
                    send_range(0, split_at);
                    wait_idle();
                    write_cfg(8'($urandom_range(0, 10)));
                    send_range(split_at, file_data.size());
                end
                else
                begin
                    send_range(0, file_data.size());
                end
            end
            phase_no++;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (strip_sb.errors == 0 && strip_sb.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
